### src/lru_key_value_cache_defines.svh
// Assertion shorthands for the cache block.
// Each one is a single concurrent assertion on a rising clock edge,
// switched off while reset is high.
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

// Condition that holds at every edge.
`define LKVC_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

// Consequence in the same cycle.
`define LKVC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequence in the cycle after.
`define LKVC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/lkvc_pkg.sv
`default_nettype none

package lkvc_pkg;

   // request kinds
   localparam logic KIND_GET = 1'b0;
   localparam logic KIND_PUT = 1'b1;

   // capacity register
   localparam int unsigned CAP_W = 5;
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // returned by a get that misses
   localparam logic signed [31:0] MISS_VALUE = 32'hFFFF_FFFF;

   typedef struct packed {
      logic               kind;
      logic signed [31:0] key;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic               found;
      logic signed [31:0] read_value;
   } rsp_type;

endpackage

`default_nettype wire

### src/lru_key_value_cache.sv
`default_nettype none
`include "lru_key_value_cache_defines.svh"

// Fully associative key/value cache with least-recently-used replacement.
// A request is a get (kind 0) or a put (kind 1); each request gives exactly
// one response. A get returns found=1 and the stored value on a hit, or
// found=0 and -1 on a miss; a put returns 0 with found telling whether the
// key was already present. One request is worked on at a time by a small
// sequencer around a single key comparator and a single rank adder, with
// keys, values and recency ranks held in memories with one registered read
// port. A scan pass reads every slot to find the hit, a free slot and the oldest
// entry; an ageing pass then goes over every slot again and rewrites the ranks.
// A request that changes recency goes through both passes before its response,
// while a get that misses skips the ageing pass. The block returns to idle
// when the response is loaded and then takes a new request, even while that
// response is still stalled.
// The capacity register (csr_wr_data) limits entries in use before eviction:
// 0 acts as 1, anything above MAX_ENTRIES acts as MAX_ENTRIES, and lowering
// it below the current fill drops nothing. Write it only while idle.
module lru_key_value_cache #(
   parameter int unsigned MAX_ENTRIES = 16   // 1 .. 256
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // request channel
   input  wire logic                        req_valid,
   output      logic                        req_stall,
   input  wire lkvc_pkg::req_type           req_data,
   // response channel
   output      logic                        rsp_valid,
   input  wire logic                        rsp_stall,
   output      lkvc_pkg::rsp_type           rsp_data,
   // capacity register
   input  wire logic                        csr_wr_en,
   input  wire logic [lkvc_pkg::CAP_W-1:0]  csr_wr_data
);

   // slot index and rank widths; ranks of valid slots are 0 .. fill-1
   localparam int unsigned IW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int unsigned RW    = IW;
   localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int unsigned CMP_W = (CNT_W > lkvc_pkg::CAP_W) ? CNT_W : lkvc_pkg::CAP_W;
   localparam logic [IW-1:0] LAST_IDX = IW'(MAX_ENTRIES - 1);

   // sequencer states
   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_SCAN      = 3'd1;   // issue key/value/rank reads
   localparam logic [2:0] ST_SCAN_LAST = 3'd2;   // last read data arrives
   localparam logic [2:0] ST_DECIDE    = 3'd3;   // hit / fill / evict choice
   localparam logic [2:0] ST_AGE       = 3'd4;   // read-modify-write of ranks
   localparam logic [2:0] ST_AGE_LAST  = 3'd5;   // last rank write-back
   localparam logic [2:0] ST_COMMIT    = 3'd6;   // slot writes and response

   // ---------------------------------------------------------------------
   // State
   // ---------------------------------------------------------------------
   logic [2:0]              state_ff,  state_in;
   logic [IW-1:0]           cnt_ff,    cnt_in;     // read address
   logic                    pv_ff,     pv_in;      // read data valid
   logic [IW-1:0]           pidx_ff,   pidx_in;    // slot of read data
   lkvc_pkg::req_type       req_ff,    req_in;
   logic [lkvc_pkg::CAP_W-1:0] cap_ff, cap_in;
   logic [CNT_W-1:0]        used_ff,   used_in;
   logic [MAX_ENTRIES-1:0]  valid_ff,  valid_in;

   // scan results
   logic                    hit_ff,    hit_in;
   logic [IW-1:0]           hidx_ff,   hidx_in;
   logic [RW-1:0]           hrank_ff,  hrank_in;
   logic signed [31:0]      hval_ff,   hval_in;
   logic                    vic_ff,    vic_in;     // a victim has been seen
   logic [IW-1:0]           vidx_ff,   vidx_in;
   logic [RW-1:0]           vrank_ff,  vrank_in;
   logic                    free_ff,   free_in;
   logic [IW-1:0]           fidx_ff,   fidx_in;

   // update plan
   logic [IW-1:0]           tgt_ff,    tgt_in;     // slot made most recent
   logic [RW-1:0]           thr_ff,    thr_in;     // younger ranks age
   logic                    all_ff,    all_in;     // every valid rank ages
   logic                    fill_ff,   fill_in;    // new pair into a free slot
   logic                    upd_ff,    upd_in;     // recency changes

   // response register
   logic                    rsp_valid_ff, rsp_valid_in;
   lkvc_pkg::rsp_type       rsp_ff,       rsp_in;

   // memories and their registered read data
   logic signed [31:0]      key_mem  [MAX_ENTRIES];
   logic signed [31:0]      val_mem  [MAX_ENTRIES];
   logic [RW-1:0]           rank_mem [MAX_ENTRIES];
   logic signed [31:0]      key_rd_ff;
   logic signed [31:0]      val_rd_ff;
   logic [RW-1:0]           rank_rd_ff;

   // memory write ports
   logic                    rank_we;
   logic [IW-1:0]           rank_waddr;
   logic [RW-1:0]           rank_wdata;
   logic                    key_we;
   logic                    val_we;

   // helpers
   logic                    go;          // response register can be loaded
   logic                    is_put;
   logic                    rd_valid;    // valid bit of the slot just read
   logic [CMP_W-1:0]        cap_ext;
   logic [CMP_W-1:0]        eff_cap;
   logic                    room;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign go       = !rsp_valid_ff || !rsp_stall;
   assign is_put   = (req_ff.kind == lkvc_pkg::KIND_PUT);
   assign rd_valid = valid_ff[pidx_ff];

   // capacity clamped to 1 .. MAX_ENTRIES
   assign cap_ext = CMP_W'(cap_ff);
   assign eff_cap = (cap_ff == '0) ? CMP_W'(1)
                  : ((cap_ext > CMP_W'(MAX_ENTRIES)) ? CMP_W'(MAX_ENTRIES) : cap_ext);
   assign room    = (CMP_W'(used_ff) < eff_cap);

   // ---------------------------------------------------------------------
   // Sequencer and shared datapath
   // ---------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      pv_in        = 1'b0;
      pidx_in      = cnt_ff;
      req_in       = req_ff;
      cap_in       = cap_ff;
      used_in      = used_ff;
      valid_in     = valid_ff;
      hit_in       = hit_ff;
      hidx_in      = hidx_ff;
      hrank_in     = hrank_ff;
      hval_in      = hval_ff;
      vic_in       = vic_ff;
      vidx_in      = vidx_ff;
      vrank_in     = vrank_ff;
      free_in      = free_ff;
      fidx_in      = fidx_ff;
      tgt_in       = tgt_ff;
      thr_in       = thr_ff;
      all_in       = all_ff;
      fill_in      = fill_ff;
      upd_in       = upd_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      rank_we      = 1'b0;
      rank_waddr   = pidx_ff;
      rank_wdata   = rank_rd_ff + RW'(1);
      key_we       = 1'b0;
      val_we       = 1'b0;

      if (csr_wr_en) begin
         cap_in = csr_wr_data;
      end

      // response taken downstream
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // one slot of scan data: the shared key comparator and rank compare
      if (pv_ff && (state_ff == ST_SCAN || state_ff == ST_SCAN_LAST)) begin
         if (rd_valid && !hit_ff && (key_rd_ff == req_ff.key)) begin
            hit_in   = 1'b1;
            hidx_in  = pidx_ff;
            hrank_in = rank_rd_ff;
            hval_in  = val_rd_ff;
         end
         if (rd_valid && (!vic_ff || (rank_rd_ff > vrank_ff))) begin
            vic_in   = 1'b1;
            vidx_in  = pidx_ff;
            vrank_in = rank_rd_ff;
         end
         if (!rd_valid && !free_ff) begin
            free_in = 1'b1;
            fidx_in = pidx_ff;
         end
      end

      // one slot of ageing: the shared rank adder, written back in place
      if (pv_ff && (state_ff == ST_AGE || state_ff == ST_AGE_LAST)) begin
         rank_we = rd_valid && (pidx_ff != tgt_ff)
                && (all_ff || (rank_rd_ff < thr_ff));
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               cnt_in   = '0;
               hit_in   = 1'b0;
               vic_in   = 1'b0;
               free_in  = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            pv_in = 1'b1;
            if (cnt_ff == LAST_IDX) begin
               cnt_in   = '0;
               state_in = ST_SCAN_LAST;
            end else begin
               cnt_in = cnt_ff + IW'(1);
            end
         end
         ST_SCAN_LAST: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            fill_in = 1'b0;
            all_in  = 1'b0;
            upd_in  = 1'b1;
            cnt_in  = '0;
            priority if (hit_ff) begin
               tgt_in = hidx_ff;
               thr_in = hrank_ff;
            end else if (is_put && room) begin
               tgt_in  = fidx_ff;
               all_in  = 1'b1;
               fill_in = 1'b1;
            end else if (is_put) begin
               tgt_in = vidx_ff;
               thr_in = vrank_ff;
            end else begin
               upd_in = 1'b0;     // get miss leaves everything alone
            end
            state_in = (hit_ff || is_put) ? ST_AGE : ST_COMMIT;
         end
         ST_AGE: begin
            pv_in = 1'b1;
            if (cnt_ff == LAST_IDX) begin
               cnt_in   = '0;
               state_in = ST_AGE_LAST;
            end else begin
               cnt_in = cnt_ff + IW'(1);
            end
         end
         ST_AGE_LAST: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (go) begin
               if (upd_ff) begin
                  rank_we    = 1'b1;
                  rank_waddr = tgt_ff;
                  rank_wdata = '0;
               end
               val_we = is_put;
               key_we = is_put && !hit_ff;
               if (fill_ff) begin
                  valid_in[tgt_ff] = 1'b1;
                  used_in          = used_ff + CNT_W'(1);
               end
               rsp_valid_in     = 1'b1;
               rsp_in.found     = hit_ff;
               rsp_in.read_value = is_put ? 32'sd0
                                 : (hit_ff ? hval_ff : lkvc_pkg::MISS_VALUE);
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         pv_ff        <= 1'b0;
         cap_ff       <= lkvc_pkg::CAP_RESET;
         used_ff      <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pv_ff        <= pv_in;
         cap_ff       <= cap_in;
         used_ff      <= used_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pidx_ff  <= pidx_in;
      req_ff   <= req_in;
      hit_ff   <= hit_in;
      hidx_ff  <= hidx_in;
      hrank_ff <= hrank_in;
      hval_ff  <= hval_in;
      vic_ff   <= vic_in;
      vidx_ff  <= vidx_in;
      vrank_ff <= vrank_in;
      free_ff  <= free_in;
      fidx_ff  <= fidx_in;
      tgt_ff   <= tgt_in;
      thr_ff   <= thr_in;
      all_ff   <= all_in;
      fill_ff  <= fill_in;
      upd_ff   <= upd_in;
      rsp_ff   <= rsp_in;
   end

   // slot memories: one write port, one registered read port at cnt_ff
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[tgt_ff] <= req_ff.key;
      end
      key_rd_ff <= key_mem[cnt_ff];
   end

   always_ff @(posedge clock) begin
      if (val_we) begin
         val_mem[tgt_ff] <= req_ff.value;
      end
      val_rd_ff <= val_mem[cnt_ff];
   end

   always_ff @(posedge clock) begin
      if (rank_we) begin
         rank_mem[rank_waddr] <= rank_wdata;
      end
      rank_rd_ff <= rank_mem[cnt_ff];
   end

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   `LKVC_ASSERT_ALWAYS(a_fill_count, clock, reset, $countones(valid_ff) == int'(used_ff), "fill count disagrees with valid bits")
   `LKVC_ASSERT_NXT(a_accept_scans, clock, reset, req_valid && !req_stall, state_ff == ST_SCAN, "accepted request did not start a scan")
   `LKVC_ASSERT_IMP(a_rsp_from_commit, clock, reset, $rose(rsp_valid), $past(state_ff) == ST_COMMIT, "response raised outside commit")
   `LKVC_ASSERT_IMP(a_fill_free_slot, clock, reset, state_ff == ST_COMMIT && fill_ff, free_ff && !valid_ff[fidx_ff] && (tgt_ff == fidx_ff), "fill aimed at an occupied slot")

endmodule

`default_nettype wire

### sim/tb_lru_key_value_cache.sv
`default_nettype none

// Self-checking bench for the LRU key/value cache.
// A shadow of the cache (slots, ranks, fill count and the capacity register)
// runs beside the block: every request accepted on the input side is played
// into it and the response it gives is queued. Responses from the block are
// popped and compared field by field. The capacity register is only written
// while the block is idle.
module tb_lru_key_value_cache;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned SLOTS      = 16;
   // a request that changes recency is the slowest: a scan pass and an ageing pass
   localparam int unsigned LATENCY    = 2 * SLOTS + 4;
   localparam int unsigned IDLE_LIMIT = 3000;   // cycles with no handshake at all
   localparam int unsigned LONG_HOLD  = 400;    // receiver back-pressure stretch
   localparam int unsigned REPORT_MAX = 10;

   // ---------------------------------------------------------------------
   // Shadow cache and queue of responses still owed by the block
   // ---------------------------------------------------------------------
   class cache_mirror;
      logic [31:0]                slot_key   [SLOTS];
      logic [31:0]                slot_val   [SLOTS];
      bit                         slot_used  [SLOTS];
      int unsigned                slot_age   [SLOTS];   // 0 = most recent
      int unsigned                fill;
      logic [lkvc_pkg::CAP_W-1:0] capacity;
      lkvc_pkg::rsp_type          rsp_due[$];
      int unsigned                failures;

      function new();
         foreach (slot_used[i]) begin
            slot_used[i] = 0;
            slot_age[i]  = 0;
            slot_key[i]  = '0;
            slot_val[i]  = '0;
         end
         fill     = 0;
         capacity = lkvc_pkg::CAP_RESET;
         failures = 0;
      endfunction

      function int unsigned pending();
         return rsp_due.size();
      endfunction

      // slot s becomes most recent; anything younger than it ages by one
      function void make_newest(int unsigned s, int unsigned old_age);
         foreach (slot_used[i]) begin
            if (slot_used[i] && i != s && slot_age[i] < old_age)
               slot_age[i]++;
         end
         slot_age[s] = 0;
      endfunction

      function void note_request(lkvc_pkg::req_type r);
         int unsigned       lim;
         int                hit;
         int                spare;
         int                victim;
         int unsigned       worst;
         lkvc_pkg::rsp_type due;

         lim = capacity;
         if (lim == 0)
            lim = 1;
         if (lim > SLOTS)
            lim = SLOTS;

         hit = -1;
         foreach (slot_used[i]) begin
            if (hit < 0 && slot_used[i] && slot_key[i] == r.key)
               hit = i;
         end

         due.found      = (hit >= 0);
         due.read_value = '0;

         if (r.kind == lkvc_pkg::KIND_GET) begin
            if (hit >= 0) begin
               due.read_value = slot_val[hit];
               make_newest(hit, slot_age[hit]);
            end else begin
               due.read_value = lkvc_pkg::MISS_VALUE;
            end
         end else if (hit >= 0) begin
            slot_val[hit] = r.value;
            make_newest(hit, slot_age[hit]);
         end else begin
            spare = -1;
            if (fill < lim) begin
               foreach (slot_used[i]) begin
                  if (spare < 0 && !slot_used[i])
                     spare = i;
               end
            end
            if (spare >= 0) begin
               // free slot: every live entry ages by one
               foreach (slot_used[i]) begin
                  if (slot_used[i])
                     slot_age[i]++;
               end
               slot_used[spare] = 1;
               slot_key[spare]  = r.key;
               slot_val[spare]  = r.value;
               slot_age[spare]  = 0;
               fill++;
            end else begin
               // full (or capacity lowered): oldest live entry goes, first on a tie
               victim = -1;
               worst  = 0;
               foreach (slot_used[i]) begin
                  if (slot_used[i] && (victim < 0 || slot_age[i] > worst)) begin
                     victim = i;
                     worst  = slot_age[i];
                  end
               end
               if (victim >= 0) begin
                  slot_key[victim] = r.key;
                  slot_val[victim] = r.value;
                  make_newest(victim, worst);
               end
            end
         end
         rsp_due.push_back(due);
      endfunction

      function void check_response(lkvc_pkg::rsp_type got);
         lkvc_pkg::rsp_type want;
         if (rsp_due.size() == 0) begin
            failures++;
            if (failures <= REPORT_MAX)
               $display("%t: response with nothing outstanding: found=%0b value=%0d",
                        $realtime, got.found, got.read_value);
            return;
         end
         want = rsp_due.pop_front();
         if (got.found !== want.found || got.read_value !== want.read_value) begin
            failures++;
            if (failures <= REPORT_MAX)
               $display("%t: mismatch: expected found=%0b value=%0d, got found=%0b value=%0d",
                        $realtime, want.found, want.read_value,
                        got.found, got.read_value);
         end
      endfunction
   endclass

   // ---------------------------------------------------------------------
   // DUT and its signals
   // ---------------------------------------------------------------------
   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   lkvc_pkg::req_type          req_data;
   logic                       rsp_valid;
   logic                       rsp_stall;
   lkvc_pkg::rsp_type          rsp_data;
   logic                       csr_wr_en;
   logic [lkvc_pkg::CAP_W-1:0] csr_wr_data;

   lru_key_value_cache #(.MAX_ENTRIES(SLOTS)) uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   cache_mirror mirror = new();

   // receiver controls, set by the main sequence
   bit          rx_steady;      // no back-pressure at all
   int unsigned hold_seq;       // bumped to ask the receiver for one long hold
   int unsigned hold_seen;
   int unsigned hold_left;
   int unsigned rx_gap_left;
   bit          tx_steady;      // requests back to back

   // key pool for the random part, so that hits and evictions are common
   logic [31:0] key_pool[32];
   int unsigned pool_len;

   int unsigned idle_run;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return $urandom_range(1, 3);
      else if (r < 94)
         return $urandom_range(4, 12);
      else
         return $urandom_range(20, 80);
   endfunction

   // ---------------------------------------------------------------------
   // Receiver: stall pattern changes on the falling edge
   // ---------------------------------------------------------------------
   initial begin
      rsp_stall   = 1'b0;
      hold_seen   = 0;
      hold_left   = 0;
      rx_gap_left = 0;
      forever begin
         @(negedge clock);
         if (hold_seq != hold_seen) begin
            hold_left = LONG_HOLD;
            hold_seen = hold_seq;
         end
         if (hold_left != 0) begin
            rsp_stall = 1'b1;
            hold_left--;
         end else if (rx_steady) begin
            rsp_stall = 1'b0;
         end else if (rx_gap_left != 0) begin
            rsp_stall = 1'b1;
            rx_gap_left--;
         end else begin
            rsp_stall = 1'b0;
            if ($urandom_range(0, 99) < 30)
               rx_gap_left = pick_gap();
         end
      end
   end

   // responses are checked at the rising edge they are taken
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         mirror.check_response(rsp_data);
   end

   // watchdog: counts cycles in which neither side hands anything over
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_run = 0;
      end else begin
         idle_run++;
         if (idle_run >= IDLE_LIMIT) begin
            $display("%t: no handshake for %0d cycles", $realtime, IDLE_LIMIT);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sender tasks
   // ---------------------------------------------------------------------
   function automatic lkvc_pkg::req_type mk_req(logic kind, logic [31:0] key,
                                                logic [31:0] value);
      lkvc_pkg::req_type r;
      r.kind  = kind;
      r.key   = key;
      r.value = value;
      return r;
   endfunction

   // offer one request and hold it until taken
   task automatic send_request(lkvc_pkg::req_type r);
      @(negedge clock);
      req_valid = 1'b1;
      req_data  = r;
      do
         @(posedge clock);
      while (req_stall);
      mirror.note_request(r);
   endtask

   task automatic sender_pause(int unsigned n);
      if (n != 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   // stop offering and wait for every owed response
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (mirror.pending() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // only called with the block idle
   task automatic write_capacity(logic [lkvc_pkg::CAP_W-1:0] cap);
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = cap;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      mirror.capacity = cap;
   endtask

   // keys for one phase; some differ from a neighbour in a single bit
   task automatic refill_pool(int unsigned n);
      pool_len = n;
      for (int i = 0; i < n; i++) begin
         if (i > 0 && $urandom_range(0, 3) == 0)
            key_pool[i] = key_pool[i-1] ^ (32'd1 << $urandom_range(0, 31));
         else
            key_pool[i] = $urandom;
      end
   endtask

   function automatic lkvc_pkg::req_type random_request();
      logic        kind;
      logic [31:0] key;
      logic [31:0] value;
      int unsigned r;
      kind = $urandom_range(0, 1) ? lkvc_pkg::KIND_PUT : lkvc_pkg::KIND_GET;
      key  = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, pool_len - 1)]
                                       : $urandom;
      r = $urandom_range(0, 19);
      case (r)
         0: value = 32'h8000_0000;
         1: value = 32'h7FFF_FFFF;
         2: value = 32'hFFFF_FFFF;
         3: value = 32'h0000_0000;
         default: value = $urandom;
      endcase
      return mk_req(kind, key, value);
   endfunction

   // one capacity setting, then a run of random requests
   task automatic run_phase(logic [lkvc_pkg::CAP_W-1:0] cap, int unsigned count,
                            bit calm_tx, bit calm_rx, bit with_hold);
      int unsigned eff;
      drain();
      write_capacity(cap);
      eff = (cap == 0) ? 1 : ((cap > SLOTS) ? SLOTS : cap);
      refill_pool(eff + 5);
      tx_steady = calm_tx;
      rx_steady = calm_rx;
      if (with_hold) begin
         // long hold on the response side while requests keep coming:
         // the block fills up and must stall its input
         @(posedge clock);
         hold_seq++;
         for (int i = 0; i < 12; i++)
            send_request(random_request());
      end
      for (int i = 0; i < count; i++) begin
         if (!tx_steady && $urandom_range(0, 99) < 40)
            sender_pause(pick_gap());
         send_request(random_request());
      end
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      csr_wr_en    = 1'b0;
      csr_wr_data  = '0;
      rx_steady    = 1'b1;
      tx_steady    = 1'b1;
      hold_seq     = 0;
      pool_len     = 1;
      key_pool[0]  = '0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // capacity zero behaves as one: the second insert evicts the first
      write_capacity(5'd0);
      send_request(mk_req(lkvc_pkg::KIND_GET, 32'h0000_0000, 32'h1234_5678)); // miss
      send_request(mk_req(lkvc_pkg::KIND_PUT, 32'h0000_00A5, 32'h0000_0001));
      send_request(mk_req(lkvc_pkg::KIND_PUT, 32'h0000_005A, 32'h0000_0002));
      send_request(mk_req(lkvc_pkg::KIND_GET, 32'h0000_00A5, 32'h0));
      send_request(mk_req(lkvc_pkg::KIND_GET, 32'h0000_005A, 32'h0));
      drain();

      // capacity above the slot count behaves as the slot count
      write_capacity(5'd31);
      rx_steady = 1'b0;
      send_request(mk_req(lkvc_pkg::KIND_PUT, 32'h8000_0000, 32'h7FFF_FFFF));
      send_request(mk_req(lkvc_pkg::KIND_PUT, 32'h7FFF_FFFF, 32'h8000_0000));
      send_request(mk_req(lkvc_pkg::KIND_PUT, 32'hFFFF_FFFF, 32'h0000_0000));
      send_request(mk_req(lkvc_pkg::KIND_PUT, 32'h0000_0000, 32'hFFFF_FFFF));
      send_request(mk_req(lkvc_pkg::KIND_GET, 32'h8000_0000, 32'h0));
      send_request(mk_req(lkvc_pkg::KIND_GET, 32'h0000_0000, 32'h0));
      send_request(mk_req(lkvc_pkg::KIND_GET, 32'h0000_0001, 32'h0));   // one bit off
      send_request(mk_req(lkvc_pkg::KIND_GET, 32'h7FFF_FFFE, 32'h0));
      send_request(mk_req(lkvc_pkg::KIND_PUT, 32'h7FFF_FFFF, 32'h0000_3039)); // update
      send_request(mk_req(lkvc_pkg::KIND_GET, 32'h7FFF_FFFF, 32'h0));
      send_request(mk_req(lkvc_pkg::KIND_GET, 32'hFFFF_FFFF, 32'h0));
      drain();

      // capacity lowered below the fill: nothing dropped, inserts replace the oldest
      write_capacity(5'd2);
      send_request(mk_req(lkvc_pkg::KIND_PUT, 32'h0000_0011, 32'hDEAD_BEEF));
      send_request(mk_req(lkvc_pkg::KIND_PUT, 32'h0000_0022, 32'h0BAD_F00D));
      send_request(mk_req(lkvc_pkg::KIND_GET, 32'h8000_0000, 32'h0));
      send_request(mk_req(lkvc_pkg::KIND_GET, 32'h0000_0011, 32'h0));
      send_request(mk_req(lkvc_pkg::KIND_GET, 32'h7FFF_FFFF, 32'h0));

      // random part, several capacity settings
      run_phase(5'd31, 230, 1'b0, 1'b0, 1'b0);
      run_phase(5'd1,  100, 1'b0, 1'b0, 1'b0);
      run_phase(5'd16, 230, 1'b0, 1'b0, 1'b1);
      run_phase(5'd4,  150, 1'b1, 1'b1, 1'b0);   // no idling on either side
      run_phase(5'd17, 150, 1'b0, 1'b0, 1'b0);
      run_phase(5'd8,  150, 1'b0, 1'b1, 1'b0);
      run_phase(5'($urandom_range(0, 31)), 150, 1'b1, 1'b0, 1'b0);

      // let everything owed come back, then give the block its latency
      @(negedge clock);
      req_valid = 1'b0;
      while (mirror.pending() != 0)
         @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);

      if (mirror.pending() != 0)
         mirror.failures++;
      if (mirror.failures == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

### filelist.f
+incdir+src
src/lkvc_pkg.sv
src/lru_key_value_cache.sv
sim/tb_lru_key_value_cache.sv
